// ----- rtl/rbsi_pkg.sv -----
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared types and constants for the ray / box slab intersection pipeline.
// ----------------------------------------------------------------------------
package rbsi_pkg;

   localparam int COORD_W   = 32;
   localparam int FRAC_BITS = 16;
   localparam int NUM_AXES  = 3;
   localparam int NUM_DIVS  = 2 * NUM_AXES;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int DVD_W     = DIFF_W + FRAC_BITS;
   localparam int DSR_W     = COORD_W;
   localparam int TIME_W    = DVD_W + 1;

   typedef struct packed {
      logic signed [COORD_W-1:0] box_x_min;
      logic signed [COORD_W-1:0] box_x_max;
      logic signed [COORD_W-1:0] box_y_min;
      logic signed [COORD_W-1:0] box_y_max;
      logic signed [COORD_W-1:0] box_z_min;
      logic signed [COORD_W-1:0] box_z_max;
      logic signed [COORD_W-1:0] ray_origin_x;
      logic signed [COORD_W-1:0] ray_origin_y;
      logic signed [COORD_W-1:0] ray_origin_z;
      logic signed [COORD_W-1:0] ray_dir_x;
      logic signed [COORD_W-1:0] ray_dir_y;
      logic signed [COORD_W-1:0] ray_dir_z;
   } req_type;

   typedef struct packed {
      logic                      hit;
      logic signed [COORD_W-1:0] entry_time;
   } rsp_type;

   typedef struct packed {
      logic [NUM_DIVS-1:0] neg;
      logic [NUM_AXES-1:0] flat;
      logic [NUM_AXES-1:0] in_slab;
   } slab_meta_type;

   typedef logic [NUM_DIVS-1:0][DVD_W-1:0] dvd_vec_type;
   typedef logic [NUM_DIVS-1:0][DSR_W-1:0] dsr_vec_type;

endpackage

// ----- rtl/ray_box_slab_intersect.sv -----
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Ray versus axis-aligned box slab test on signed Q16.16 coordinates.
// ----------------------------------------------------------------------------
// Accepts one transaction per cycle when not stalled and returns one result per
// transaction, in order, after slab setup, the bit-per-stage restoring divider
// that forms all six slab times in parallel, and the order, fold and saturate
// steps. The whole pipeline holds while a result waits on rsp_ready; req_ready
// then drops.
module ray_box_slab_intersect (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rbsi_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rbsi_pkg::rsp_type rsp_data
);
   import rbsi_pkg::*;

   logic          advance;
   logic          prep_valid;
   dvd_vec_type   prep_dvd;
   dsr_vec_type   prep_dsr;
   slab_meta_type prep_meta;
   logic          div_valid;
   dvd_vec_type   div_quo;
   slab_meta_type div_meta;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   rbsi_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (prep_valid),
      .out_dvd   (prep_dvd),
      .out_dsr   (prep_dsr),
      .out_meta  (prep_meta)
   );

   rbsi_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (prep_valid),
      .in_dvd    (prep_dvd),
      .in_dsr    (prep_dsr),
      .in_meta   (prep_meta),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_meta  (div_meta)
   );

   rbsi_resolve u_resolve (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (div_valid),
      .in_quo    (div_quo),
      .in_meta   (div_meta),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_miss_max : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.entry_time == 32'sh7FFFFFFF)
      else $error("miss result without maximum entry time");

   a_reset_empty : assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_holds_input : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while pipeline stalled");
`endif

endmodule

// ----- rtl/rbsi_prep.sv -----
// ----------------------------------------------------------------------------
// rbsi_prep
// Slab differences, magnitudes and signs, zero-direction and in-slab checks.
// ----------------------------------------------------------------------------
module rbsi_prep (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  rbsi_pkg::req_type     in_data,
   output logic                  out_valid,
   output rbsi_pkg::dvd_vec_type out_dvd,
   output rbsi_pkg::dsr_vec_type out_dsr,
   output rbsi_pkg::slab_meta_type out_meta
);
   import rbsi_pkg::*;

   logic signed [COORD_W-1:0] lo [NUM_AXES];
   logic signed [COORD_W-1:0] hi [NUM_AXES];
   logic signed [COORD_W-1:0] org [NUM_AXES];
   logic signed [COORD_W-1:0] dir [NUM_AXES];

   logic          valid_ff;
   dvd_vec_type   dvd_ff, dvd_in;
   dsr_vec_type   dsr_ff, dsr_in;
   slab_meta_type meta_ff, meta_in;

   assign lo[0]  = in_data.box_x_min;
   assign hi[0]  = in_data.box_x_max;
   assign lo[1]  = in_data.box_y_min;
   assign hi[1]  = in_data.box_y_max;
   assign lo[2]  = in_data.box_z_min;
   assign hi[2]  = in_data.box_z_max;
   assign org[0] = in_data.ray_origin_x;
   assign org[1] = in_data.ray_origin_y;
   assign org[2] = in_data.ray_origin_z;
   assign dir[0] = in_data.ray_dir_x;
   assign dir[1] = in_data.ray_dir_y;
   assign dir[2] = in_data.ray_dir_z;

   always_comb begin
      logic signed [DIFF_W-1:0] diff;
      logic        [DIFF_W-1:0] mag;
      logic        [DSR_W-1:0]  dmag;
      dvd_in  = '0;
      dsr_in  = '0;
      meta_in = '0;
      diff    = '0;
      mag     = '0;
      dmag    = '0;
      for (int a = 0; a < NUM_AXES; a++) begin
         dmag = dir[a][COORD_W-1] ? DSR_W'(-dir[a]) : DSR_W'(dir[a]);
         meta_in.flat[a]    = (dir[a] == '0);
         meta_in.in_slab[a] = !((org[a] < lo[a]) || (hi[a] < org[a]));
         for (int b = 0; b < 2; b++) begin
            diff = (b == 0) ? (DIFF_W'(lo[a]) - DIFF_W'(org[a]))
                            : (DIFF_W'(hi[a]) - DIFF_W'(org[a]));
            mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
            dvd_in[2*a+b]       = {mag, {FRAC_BITS{1'b0}}};
            dsr_in[2*a+b]       = dmag;
            meta_in.neg[2*a+b]  = diff[DIFF_W-1] ^ dir[a][COORD_W-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dvd_ff  <= dvd_in;
         dsr_ff  <= dsr_in;
         meta_ff <= meta_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_dvd   = dvd_ff;
   assign out_dsr   = dsr_ff;
   assign out_meta  = meta_ff;

endmodule

// ----- rtl/rbsi_divider.sv -----
// ----------------------------------------------------------------------------
// rbsi_divider
// Six-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rbsi_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  rbsi_pkg::dvd_vec_type   in_dvd,
   input  rbsi_pkg::dsr_vec_type   in_dsr,
   input  rbsi_pkg::slab_meta_type in_meta,
   output logic                    out_valid,
   output rbsi_pkg::dvd_vec_type   out_quo,
   output rbsi_pkg::slab_meta_type out_meta
);
   import rbsi_pkg::*;

   logic          valid_ff [1:DVD_W];
   dvd_vec_type   work_ff  [1:DVD_W];
   dsr_vec_type   rem_ff   [1:DVD_W];
   dsr_vec_type   dsr_ff   [1:DVD_W];
   slab_meta_type meta_ff  [1:DVD_W];

   for (genvar s = 0; s < DVD_W; s++) begin : g_stage
      logic          src_valid;
      dvd_vec_type   src_work;
      dsr_vec_type   src_rem;
      dsr_vec_type   src_dsr;
      slab_meta_type src_meta;
      dvd_vec_type   work_in;
      dsr_vec_type   rem_in;

      if (s == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_work  = in_dvd;
         assign src_rem   = '0;
         assign src_dsr   = in_dsr;
         assign src_meta  = in_meta;
      end else begin : g_next
         assign src_valid = valid_ff[s];
         assign src_work  = work_ff[s];
         assign src_rem   = rem_ff[s];
         assign src_dsr   = dsr_ff[s];
         assign src_meta  = meta_ff[s];
      end

      always_comb begin
         logic [DSR_W:0] trial;
         trial = '0;
         for (int l = 0; l < NUM_DIVS; l++) begin
            trial = {src_rem[l], src_work[l][DVD_W-1]};
            if (trial >= {1'b0, src_dsr[l]}) begin
               rem_in[l]  = DSR_W'(trial - {1'b0, src_dsr[l]});
               work_in[l] = {src_work[l][DVD_W-2:0], 1'b1};
            end else begin
               rem_in[l]  = trial[DSR_W-1:0];
               work_in[l] = {src_work[l][DVD_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[s+1] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            work_ff[s+1] <= work_in;
            rem_ff[s+1]  <= rem_in;
            dsr_ff[s+1]  <= src_dsr;
            meta_ff[s+1] <= src_meta;
         end
      end
   end

   assign out_valid = valid_ff[DVD_W];
   assign out_quo   = work_ff[DVD_W];
   assign out_meta  = meta_ff[DVD_W];

endmodule

// ----- rtl/rbsi_resolve.sv -----
// ----------------------------------------------------------------------------
// rbsi_resolve
// Signs and orders slab times, folds entry/exit, decides hit, saturates.
// ----------------------------------------------------------------------------
module rbsi_resolve (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  rbsi_pkg::dvd_vec_type   in_quo,
   input  rbsi_pkg::slab_meta_type in_meta,
   output logic                    out_valid,
   output rbsi_pkg::rsp_type       out_data
);
   import rbsi_pkg::*;

   localparam logic signed [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   // stage 1: signed, ordered slab times
   logic                     s1_valid_ff;
   logic signed [TIME_W-1:0] near_ff [NUM_AXES];
   logic signed [TIME_W-1:0] far_ff  [NUM_AXES];
   logic signed [TIME_W-1:0] near_in [NUM_AXES];
   logic signed [TIME_W-1:0] far_in  [NUM_AXES];
   logic [NUM_AXES-1:0]      flat_ff;
   logic [NUM_AXES-1:0]      in_slab_ff;

   // stage 2: folded window
   logic                     s2_valid_ff;
   logic signed [TIME_W-1:0] t_near_ff, t_near_in;
   logic signed [TIME_W-1:0] t_far_ff, t_far_in;
   logic                     limited_ff, limited_in;
   logic                     miss_ff, miss_in;

   // stage 3: result
   logic    s3_valid_ff;
   rsp_type rsp_ff, rsp_in;

   always_comb begin
      logic signed [TIME_W-1:0] ta;
      logic signed [TIME_W-1:0] tb;
      ta = '0;
      tb = '0;
      for (int a = 0; a < NUM_AXES; a++) begin
         ta = in_meta.neg[2*a]   ? -$signed({1'b0, in_quo[2*a]})
                                 :  $signed({1'b0, in_quo[2*a]});
         tb = in_meta.neg[2*a+1] ? -$signed({1'b0, in_quo[2*a+1]})
                                 :  $signed({1'b0, in_quo[2*a+1]});
         near_in[a] = (ta > tb) ? tb : ta;
         far_in[a]  = (ta > tb) ? ta : tb;
      end
   end

   always_comb begin
      t_near_in  = '0;
      t_far_in   = '0;
      limited_in = 1'b0;
      miss_in    = 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
         if (flat_ff[a]) begin
            if (!in_slab_ff[a]) begin
               miss_in = 1'b1;
            end
         end else begin
            if (!limited_in || near_ff[a] > t_near_in) begin
               t_near_in = near_ff[a];
            end
            if (!limited_in || far_ff[a] < t_far_in) begin
               t_far_in = far_ff[a];
            end
            limited_in = 1'b1;
         end
      end
   end

   always_comb begin
      logic hit;
      logic in_range;
      hit      = !miss_ff && !(limited_ff && (t_near_ff > t_far_ff))
                 && !(limited_ff && t_far_ff[TIME_W-1]);
      in_range = (t_near_ff[TIME_W-1:COORD_W-1] == '0)
                 || (t_near_ff[TIME_W-1:COORD_W-1] == '1);
      rsp_in.hit = hit;
      priority if (!hit) begin
         rsp_in.entry_time = SAT_MAX;
      end else if (!limited_ff) begin
         rsp_in.entry_time = SAT_MIN;
      end else if (in_range) begin
         rsp_in.entry_time = t_near_ff[COORD_W-1:0];
      end else if (t_near_ff[TIME_W-1]) begin
         rsp_in.entry_time = SAT_MIN;
      end else begin
         rsp_in.entry_time = SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         near_ff    <= near_in;
         far_ff     <= far_in;
         flat_ff    <= in_meta.flat;
         in_slab_ff <= in_meta.in_slab;
         t_near_ff  <= t_near_in;
         t_far_ff   <= t_far_in;
         limited_ff <= limited_in;
         miss_ff    <= miss_in;
         rsp_ff     <= rsp_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = rsp_ff;

endmodule
